[rtl/core/plta_pkg.sv]
// Shared types and constants of the peer learning table with aging.
`default_nettype none

package plta_pkg;

  localparam logic [31:0] LOCAL_ID_RESET  = 32'd1;
  localparam logic [31:0] AGE_LIMIT_RESET = 32'd15000;

  // Configuration register indexes (byte address 4*index).
  localparam logic REG_LOCAL_ID  = 1'b0;
  localparam logic REG_AGE_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    FUNC_ANNOUNCE = 2'd0,
    FUNC_SWEEP    = 2'd1,
    FUNC_READ     = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    STAT_UPDATED  = 3'd0,
    STAT_INSERTED = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_OWN      = 3'd3,
    STAT_OTHER    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_MOVE,
    S_APPEND,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] now_ticks;
    logic [31:0] peer_key;
    logic [31:0] peer_addr;
    logic [15:0] peer_port_in;
    logic        peer_auto_in;
    logic        peer_ready_in;
    logic [31:0] peer_target;
    logic [3:0]  read_index;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  peer_count;
    logic [4:0]  expired_count;
    logic        rd_valid;
    logic [31:0] rd_key;
    logic [31:0] rd_addr;
    logic [15:0] rd_port;
    logic        rd_auto;
    logic        rd_ready;
    logic        rd_challenging;
    logic [31:0] rd_last_seen;
  } out_word_t;

  // Flags: bit 0 auto connect, bit 1 ready, bit 2 challenging.
  typedef struct packed {
    logic [31:0] key;
    logic [31:0] addr;
    logic [15:0] port;
    logic [2:0]  flags;
    logic [31:0] seen;
  } entry_t;

endpackage

`default_nettype wire

[rtl/core/plta_mem.sv]
// Single-port entry memory with registered read data.
`default_nettype none

module plta_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire plta_pkg::entry_t wdata_i,
  output plta_pkg::entry_t      rdata_o
);
  import plta_pkg::*;

  entry_t mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem_q[addr_i];
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/plta_seq.sv]
// Sequencer that walks the entry memory for lookup, insert, sweep and read.
`default_nettype none

module plta_seq #(
  parameter int TABLE_DEPTH = 16,
  parameter int AW          = 4,
  parameter int CW          = 5
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire plta_pkg::in_word_t in_i,
  output logic                    res_valid_o,
  input  wire logic               res_ready_i,
  output plta_pkg::out_word_t     res_o,
  input  wire logic [31:0]        local_id_i,
  input  wire logic [31:0]        age_limit_i,
  output logic                    mem_en_o,
  output logic                    mem_we_o,
  output logic [AW-1:0]           mem_addr_o,
  output plta_pkg::entry_t        mem_wdata_o,
  input  wire plta_pkg::entry_t   mem_rdata_i
);
  import plta_pkg::*;

  state_e         state_q, state_d;
  in_word_t       item_q, item_d;
  logic [CW-1:0]  idx_q, idx_d;
  logic [CW-1:0]  total_q, total_d;
  logic [CW-1:0]  expired_q, expired_d;
  logic [2:0]     status_q, status_d;
  entry_t         rd_q, rd_d;
  logic           rd_hit_q, rd_hit_d;

  func_e          func_in, func_cur;
  logic           own_id, rd_in_range, is_last, key_hit, aged, full, chal;
  logic [CW-1:0]  idx_inc;
  entry_t         new_entry;

  assign func_in     = func_e'(in_i.func);
  assign func_cur    = func_e'(item_q.func);
  assign own_id      = in_i.peer_key == local_id_i;
  assign rd_in_range = 32'(in_i.read_index) < 32'(total_q);
  assign idx_inc     = idx_q + CW'(1);
  assign is_last     = idx_inc == total_q;
  assign key_hit     = mem_rdata_i.key == item_q.peer_key;
  assign aged        = (item_q.now_ticks - mem_rdata_i.seen) > age_limit_i;
  assign full        = total_q == CW'(TABLE_DEPTH);
  assign chal        = (item_q.peer_target != 32'd0) && (item_q.peer_target == local_id_i);

  always_comb begin
    new_entry.key   = item_q.peer_key;
    new_entry.addr  = item_q.peer_addr;
    new_entry.port  = item_q.peer_port_in;
    new_entry.flags = {chal, item_q.peer_ready_in, item_q.peer_auto_in};
    new_entry.seen  = item_q.now_ticks;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (func_in)
            FUNC_ANNOUNCE: begin
              if (own_id) state_d = S_DONE;
              else if (total_q == '0) state_d = S_APPEND;
              else state_d = S_RD;
            end
            FUNC_SWEEP: state_d = (total_q == '0) ? S_DONE : S_RD;
            FUNC_READ:  state_d = rd_in_range ? S_RD : S_DONE;
            default:    state_d = S_DONE;
          endcase
        end
      end
      S_RD: state_d = S_CHK;
      S_CHK: begin
        unique case (func_cur)
          FUNC_ANNOUNCE: begin
            if (key_hit) state_d = S_DONE;
            else if (is_last) state_d = full ? S_DONE : S_APPEND;
            else state_d = S_RD;
          end
          FUNC_SWEEP: begin
            if (aged) state_d = S_MOVE;
            else if (is_last) state_d = S_DONE;
            else state_d = S_RD;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_MOVE:   state_d = is_last ? S_DONE : S_RD;
      S_APPEND: state_d = S_DONE;
      S_DONE:   if (res_ready_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Memory controls and datapath.
  always_comb begin
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    mem_en_o    = 1'b0;
    mem_we_o    = 1'b0;
    mem_addr_o  = idx_q[AW-1:0];
    mem_wdata_o = new_entry;
    item_d      = item_q;
    idx_d       = idx_q;
    total_d     = total_q;
    expired_d   = expired_q;
    status_d    = status_q;
    rd_d        = rd_q;
    rd_hit_d    = rd_hit_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          item_d    = in_i;
          idx_d     = (func_in == FUNC_READ) ? CW'(in_i.read_index) : '0;
          expired_d = '0;
          rd_d      = '0;
          rd_hit_d  = 1'b0;
          status_d  = (func_in == FUNC_ANNOUNCE && own_id) ? STAT_OWN : STAT_OTHER;
        end
      end
      S_RD: mem_en_o = 1'b1;
      S_CHK: begin
        unique case (func_cur)
          FUNC_ANNOUNCE: begin
            if (key_hit) begin
              mem_en_o = 1'b1;
              mem_we_o = 1'b1;
              status_d = STAT_UPDATED;
            end else if (is_last) begin
              if (full) status_d = STAT_FULL;
            end else begin
              idx_d = idx_inc;
            end
          end
          FUNC_SWEEP: begin
            if (aged) begin
              // Fetch the last entry to fill the freed slot.
              mem_en_o   = 1'b1;
              mem_addr_o = AW'(total_q - CW'(1));
            end else begin
              idx_d = idx_inc;
            end
          end
          default: begin
            rd_d     = mem_rdata_i;
            rd_hit_d = 1'b1;
          end
        endcase
      end
      S_MOVE: begin
        mem_en_o    = 1'b1;
        mem_we_o    = 1'b1;
        mem_wdata_o = mem_rdata_i;
        total_d     = total_q - CW'(1);
        expired_d   = expired_q + CW'(1);
      end
      S_APPEND: begin
        mem_en_o   = 1'b1;
        mem_we_o   = 1'b1;
        mem_addr_o = AW'(total_q);
        total_d    = total_q + CW'(1);
        status_d   = STAT_INSERTED;
      end
      S_DONE: res_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    res_o.status         = status_q;
    res_o.peer_count     = 5'(total_q);
    res_o.expired_count  = 5'(expired_q);
    res_o.rd_valid       = rd_hit_q;
    res_o.rd_key         = rd_q.key;
    res_o.rd_addr        = rd_q.addr;
    res_o.rd_port        = rd_q.port;
    res_o.rd_auto        = rd_q.flags[0];
    res_o.rd_ready       = rd_q.flags[1];
    res_o.rd_challenging = rd_q.flags[2];
    res_o.rd_last_seen   = rd_q.seen;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    idx_q     <= idx_d;
    expired_q <= expired_d;
    status_q  <= status_d;
    rd_q      <= rd_d;
    rd_hit_q  <= rd_hit_d;
  end

endmodule

`default_nettype wire

[rtl/core/peer_learning_table_aging_core.sv]
// Top level of the peer learning table with aging: config port, sequencer, memory, output word.
`default_nettype none

// Peer learning table with aging. Holds up to TABLE_DEPTH peers in one
// single-port entry memory with registered read data and handles one input
// word at a time: it takes the word, works through it, then hands its result
// to the output register. An announcement scans the stored entries with a
// read and a compare each (a refresh writes in the compare state) and appends
// a newcomer after the scan; with the table full a newcomer is dropped
// without an append. A word with the local id goes straight to its result. A
// sweep reads and compares each entry; for a removed entry the compare state
// also fetches the last entry, which a move then writes into the freed slot.
// A read fetches the entry when the index is below the entry count and goes
// straight to its result otherwise, as does the unused code. Every memory
// access has its own state, so reads and writes of one entry never overlap
// and need no forwarding. The next input word is taken once the previous
// result sits in the output register, even while that word still waits for
// the consumer. Memory entries at or above the entry count are never read, so
// the memory has no clearing pass. Config registers sit at byte addresses 0
// (local_id) and 4 (age_limit); write them only while the block is idle.
module peer_learning_table_aging_core #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire plta_pkg::in_word_t  in_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output plta_pkg::out_word_t      out_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import plta_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [31:0] local_id_q, age_limit_q;
  logic        cfg_wr;

  logic        res_valid, res_ready;
  out_word_t   res;
  logic        out_valid_q;
  out_word_t   out_q;

  logic          mem_en, mem_we;
  logic [AW-1:0] mem_addr;
  entry_t        mem_wdata, mem_rdata;

  // Config port: zero wait states, word select by address bit 2.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_AGE_LIMIT) ? age_limit_q : local_id_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_id_q  <= LOCAL_ID_RESET;
      age_limit_q <= AGE_LIMIT_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_LOCAL_ID) local_id_q <= pwdata;
      else age_limit_q <= pwdata;
    end
  end

  plta_seq #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW),
    .CW          (CW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .local_id_i  (local_id_q),
    .age_limit_i (age_limit_q),
    .mem_en_o    (mem_en),
    .mem_we_o    (mem_we),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  plta_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // Output register: load a finished word when the slot is empty or drains now.
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

[rtl/core/plta_checker.sv]
// Port-level assertions for the peer learning table, bound to the top level.
`default_nettype none

module plta_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire plta_pkg::out_word_t out_o
);
  import plta_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_o))
    else $error("result word changed while stalled");

  a_expired_sweep_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status != STAT_OTHER |-> out_o.expired_count == 5'd0)
    else $error("expired count on a non-sweep word");

  a_read_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.rd_valid |->
      out_o.rd_key == 32'd0 && out_o.rd_last_seen == 32'd0 && out_o.rd_port == 16'd0)
    else $error("entry fields set without a valid read");

  a_read_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.rd_valid |-> out_o.status == STAT_OTHER)
    else $error("read hit with announcement status");

endmodule

bind peer_learning_table_aging_core plta_checker u_plta_checker (.*);

`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench of the peer learning table with aging core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import plta_pkg::*;

  // Table depth of the instance and the code that the block treats as a no-op.
  localparam int          TABLE_DEPTH  = 16;
  localparam logic [1:0]  FUNC_UNUSED  = 2'd3;
  // Slowest word is a sweep that expires a full table: drain for longer than
  // such a sweep after the last result so a stray word still shows up.
  localparam int          DRAIN_CYCLES = 60;
  localparam int          KEY_POOL     = 20;
  localparam longint      TIMEOUT_NS   = 10_000_000;

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;

  // Input channel, driven only by the word driver process.
  logic        in_valid = 1'b0;
  in_word_t    in_word = '0;
  logic        in_ready;

  // Output channel; out_ready is driven only by the stall generator.
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   dut_out;

  // Configuration port, driven only by the test sequence.
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Mirror of the table: entries, count and the two registers.
  entry_t      tbl_entry [TABLE_DEPTH];
  int          tbl_total = 0;
  logic [31:0] tbl_local_id = LOCAL_ID_RESET;
  logic [31:0] tbl_age_limit = AGE_LIMIT_RESET;

  // Words waiting to go out, words not yet accepted, results not yet seen.
  in_word_t    tx_words [$];
  int          words_in_flight = 0;
  out_word_t   pending_results [$];

  // Idling knobs in percent (gaps per word, stalls per cycle) and the stall state of the receiver.
  int          gap_pct = 0;
  int          stall_pct = 0;
  int          stall_left = 0;

  // Random stimulus state: running time, its step size and the key pool.
  logic [31:0] time_base = '0;
  int unsigned tick_step = 1000;
  logic [31:0] key_pool [KEY_POOL];

  int          error_count = 0;
  int          results_checked = 0;
  int          settings_applied = 0;
  int          n_by_func [4] = '{default: 0};
  int          n_by_status [8] = '{default: 0};
  int          n_expired = 0;
  int          n_read_valid = 0;

  peer_learning_table_aging_core #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (dut_out),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Table predictor
  // ---------------------------------------------------------------------------

  // Build the entry an announcement stores; a zero target never challenges.
  function automatic entry_t make_entry(in_word_t w);
    entry_t e;
    logic   chal;
    chal    = (w.peer_target != '0) && (w.peer_target == tbl_local_id);
    e.key   = w.peer_key;
    e.addr  = w.peer_addr;
    e.port  = w.peer_port_in;
    e.flags = {chal, w.peer_ready_in, w.peer_auto_in};
    e.seen  = w.now_ticks;
    return e;
  endfunction

  // Apply one word to the mirror and return the result word it must produce.
  function automatic out_word_t predict_table(in_word_t w);
    out_word_t   r;
    int          i;
    bit          hit;
    int          removed;
    logic [31:0] age;
    r         = '0;
    r.status  = STAT_OTHER;
    removed   = 0;
    hit       = 1'b0;
    case (w.func)
      FUNC_ANNOUNCE: begin
        if (w.peer_key == tbl_local_id) begin
          r.status = STAT_OWN;
        end else begin
          for (i = 0; i < tbl_total && !hit; i++) begin
            if (tbl_entry[i].key == w.peer_key) begin
              tbl_entry[i] = make_entry(w);
              hit = 1'b1;
            end
          end
          if (hit) begin
            r.status = STAT_UPDATED;
          end else if (tbl_total < TABLE_DEPTH) begin
            tbl_entry[tbl_total] = make_entry(w);
            tbl_total++;
            r.status = STAT_INSERTED;
          end else begin
            r.status = STAT_FULL;
          end
        end
      end
      FUNC_SWEEP: begin
        // Move the last entry into a freed slot and look at that slot again.
        i = 0;
        while (i < tbl_total) begin
          age = w.now_ticks - tbl_entry[i].seen;
          if (age > tbl_age_limit) begin
            tbl_entry[i] = tbl_entry[tbl_total - 1];
            tbl_total--;
            removed++;
          end else begin
            i++;
          end
        end
      end
      FUNC_READ: begin
        if (w.read_index < tbl_total) begin
          r.rd_valid       = 1'b1;
          r.rd_key         = tbl_entry[w.read_index].key;
          r.rd_addr        = tbl_entry[w.read_index].addr;
          r.rd_port        = tbl_entry[w.read_index].port;
          r.rd_auto        = tbl_entry[w.read_index].flags[0];
          r.rd_ready       = tbl_entry[w.read_index].flags[1];
          r.rd_challenging = tbl_entry[w.read_index].flags[2];
          r.rd_last_seen   = tbl_entry[w.read_index].seen;
        end
      end
      default: ;
    endcase
    r.peer_count    = 5'(tbl_total);
    r.expired_count = 5'(removed);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got 0x%08h, want 0x%08h (result %0d)",
             $realtime, what, got, want, results_checked);
    error_count++;
  endtask

  task automatic check_result(out_word_t got);
    out_word_t want;
    results_checked++;
    if (pending_results.size() == 0) begin
      report_mismatch("result word with nothing pending", 32'(got.status), '0);
      return;
    end
    want = pending_results.pop_front();
    if (got.status !== want.status)
      report_mismatch("status", 32'(got.status), 32'(want.status));
    if (got.peer_count !== want.peer_count)
      report_mismatch("peer_count", 32'(got.peer_count), 32'(want.peer_count));
    if (got.expired_count !== want.expired_count)
      report_mismatch("expired_count", 32'(got.expired_count), 32'(want.expired_count));
    if (got.rd_valid !== want.rd_valid)
      report_mismatch("rd_valid", 32'(got.rd_valid), 32'(want.rd_valid));
    if (got.rd_key !== want.rd_key)
      report_mismatch("rd_key", got.rd_key, want.rd_key);
    if (got.rd_addr !== want.rd_addr)
      report_mismatch("rd_addr", got.rd_addr, want.rd_addr);
    if (got.rd_port !== want.rd_port)
      report_mismatch("rd_port", 32'(got.rd_port), 32'(want.rd_port));
    if (got.rd_auto !== want.rd_auto)
      report_mismatch("rd_auto", 32'(got.rd_auto), 32'(want.rd_auto));
    if (got.rd_ready !== want.rd_ready)
      report_mismatch("rd_ready", 32'(got.rd_ready), 32'(want.rd_ready));
    if (got.rd_challenging !== want.rd_challenging)
      report_mismatch("rd_challenging", 32'(got.rd_challenging), 32'(want.rd_challenging));
    if (got.rd_last_seen !== want.rd_last_seen)
      report_mismatch("rd_last_seen", got.rd_last_seen, want.rd_last_seen);
  endtask

  // Sample the result channel at the edge; values read here are pre-edge.
  always @(posedge clk_i) begin
    if (rst_n && out_valid && out_ready) check_result(dut_out);
  end

  // ---------------------------------------------------------------------------
  // Idling on both sides
  // ---------------------------------------------------------------------------

  // Mostly short gaps, now and then a long one.
  function automatic int pick_idle(int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Drop out_ready for random stretches; the lengths follow pick_idle.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_ready  <= 1'b0;
      stall_left <= pick_idle(100) - 1;
    end else begin
      out_ready  <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Word driver: the only process that touches in_valid and in_word.
  // At each edge it takes note of an accepted word, predicts its result and
  // then decides what the channel carries next, with a single assignment to
  // in_valid per edge, so a word that follows directly keeps valid high.
  // ---------------------------------------------------------------------------
  initial begin : word_driver
    int        gap_left;
    out_word_t predicted;
    gap_left = 0;
    while (!rst_n) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (in_valid && in_ready) begin
        predicted = predict_table(in_word);
        pending_results.push_back(predicted);
        words_in_flight--;
        n_by_func[in_word.func]++;
        n_by_status[predicted.status]++;
        n_expired    += predicted.expired_count;
        n_read_valid += predicted.rd_valid;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (tx_words.size() != 0) begin
          in_word  <= tx_words.pop_front();
          in_valid <= 1'b1;
          gap_left = pick_idle(gap_pct);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Queue one word for the driver; keep at most one waiting behind it.
  task automatic send_word(in_word_t w);
    tx_words.push_back(w);
    words_in_flight++;
    while (tx_words.size() > 1) @(posedge clk_i);
  endtask

  // Hold until every queued word is accepted and every result has come back.
  task automatic wait_results_drained();
    while (words_in_flight != 0 || pending_results.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Read a register back and compare it with the value it must hold.
  task automatic apb_check(logic [2:0] addr, logic [31:0] want);
    logic [31:0] got;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want) report_mismatch($sformatf("register at 0x%0h", addr), got, want);
  endtask

  // Write both registers while the block is idle and mirror them.
  task automatic apply_settings(logic [31:0] lid, logic [31:0] age);
    wait_results_drained();
    apb_write({REG_LOCAL_ID, 2'b00}, lid);
    apb_write({REG_AGE_LIMIT, 2'b00}, age);
    apb_check({REG_LOCAL_ID, 2'b00}, lid);
    apb_check({REG_AGE_LIMIT, 2'b00}, age);
    tbl_local_id  = lid;
    tbl_age_limit = age;
    settings_applied++;
  endtask

  // ---------------------------------------------------------------------------
  // Word builders
  // ---------------------------------------------------------------------------

  function automatic in_word_t make_announce(logic [31:0] now, logic [31:0] key,
                                             logic [31:0] addr, logic [15:0] port,
                                             logic auto_f, logic ready_f,
                                             logic [31:0] target);
    in_word_t w;
    w               = '0;
    w.func          = FUNC_ANNOUNCE;
    w.now_ticks     = now;
    w.peer_key      = key;
    w.peer_addr     = addr;
    w.peer_port_in  = port;
    w.peer_auto_in  = auto_f;
    w.peer_ready_in = ready_f;
    w.peer_target   = target;
    w.read_index    = 4'($urandom);
    return w;
  endfunction

  // Sweep, read or unused code; the announcement fields carry junk.
  function automatic in_word_t make_command(logic [1:0] func, logic [31:0] now,
                                            logic [3:0] idx);
    in_word_t w;
    w             = '0;
    w.func        = func;
    w.now_ticks   = now;
    w.read_index  = idx;
    w.peer_key    = $urandom;
    w.peer_addr   = $urandom;
    w.peer_target = $urandom;
    return w;
  endfunction

  // Mostly announcements from a small key pool over a running clock, so that
  // entries get refreshed, the table fills and sweeps find stale entries.
  function automatic in_word_t make_random_word();
    in_word_t w;
    int       pick;
    w    = '0;
    pick = $urandom_range(0, 99);
    if (pick < 55)      w.func = FUNC_ANNOUNCE;
    else if (pick < 72) w.func = FUNC_SWEEP;
    else if (pick < 95) w.func = FUNC_READ;
    else                w.func = FUNC_UNUSED;
    if ($urandom_range(0, 19) == 0) begin
      w.now_ticks = $urandom;
    end else begin
      time_base   = time_base + $urandom_range(0, tick_step);
      w.now_ticks = time_base;
    end
    pick = $urandom_range(0, 99);
    if (pick < 84)      w.peer_key = key_pool[$urandom_range(0, KEY_POOL - 1)];
    else if (pick < 90) w.peer_key = tbl_local_id;
    else                w.peer_key = $urandom;
    w.peer_addr     = $urandom;
    w.peer_port_in  = 16'($urandom);
    w.peer_auto_in  = 1'($urandom);
    w.peer_ready_in = 1'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 30)      w.peer_target = tbl_local_id;
    else if (pick < 60) w.peer_target = '0;
    else                w.peer_target = $urandom;
    w.read_index = 4'($urandom);
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Registers hold their reset values; an empty table reads, sweeps and
  // ignores the unused code without touching anything.
  task automatic test_reset_state();
    apb_check({REG_LOCAL_ID, 2'b00}, LOCAL_ID_RESET);
    apb_check({REG_AGE_LIMIT, 2'b00}, AGE_LIMIT_RESET);
    send_word(make_command(FUNC_READ, 32'd0, 4'd0));
    send_word(make_command(FUNC_READ, 32'd0, 4'hF));
    send_word(make_command(FUNC_SWEEP, 32'd0, 4'd0));
    send_word(make_command(FUNC_UNUSED, '1, 4'hF));
    wait_results_drained();
  endtask

  // Fill the table to the brim, drop a newcomer, refresh an entry, then age
  // out a few entries, one of them seen in the future.
  task automatic test_directed_table();
    logic [31:0] key;
    logic [31:0] addr;
    logic [15:0] port;
    logic [31:0] target;
    logic [31:0] now;
    gap_pct   = 20;
    stall_pct = 20;
    send_word(make_announce(32'd100, LOCAL_ID_RESET, '1, '1, 1'b1, 1'b1, LOCAL_ID_RESET));
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      key    = (i == 0) ? '0 : (i == 1) ? '1 : 32'h5A00_0000 + i;
      addr   = (i == 0) ? '0 : (i == 1) ? '1 : $urandom;
      port   = (i == 0) ? '0 : (i == 1) ? '1 : 16'($urandom);
      target = (i == 2) ? LOCAL_ID_RESET : (i == 3) ? '0 : 32'hC000_0000 + i;
      // Last entry is stamped ahead of the sweep below and so counts as old.
      now    = (i == TABLE_DEPTH - 1) ? 32'd60000 : 32'd100 + i * 1000;
      send_word(make_announce(now, key, addr, port, i[0], i[1], target));
    end
    send_word(make_announce(32'd15500, 32'h0000_7777, $urandom, 16'($urandom), 1'b1, 1'b0,
                            '0));
    send_word(make_announce(32'd16000, '1, 32'h0A00_0001, 16'h1F90, 1'b0, 1'b1,
                            LOCAL_ID_RESET));
    send_word(make_command(FUNC_READ, 32'd16000, 4'd1));
    send_word(make_command(FUNC_READ, 32'd16000, 4'hF));
    send_word(make_command(FUNC_UNUSED, 32'd16000, 4'd3));
    send_word(make_command(FUNC_SWEEP, 32'd18000, 4'd0));
    send_word(make_command(FUNC_READ, 32'd18000, 4'd0));
    send_word(make_command(FUNC_READ, 32'd18000, 4'hF));
    wait_results_drained();
  endtask

  // With local_id at zero, key zero is ignored and a zero target must still
  // not mark a challenge; then read every slot.
  task automatic test_zero_local_id();
    apply_settings('0, AGE_LIMIT_RESET);
    send_word(make_announce(32'd18100, '0, $urandom, 16'($urandom), 1'b1, 1'b1, '0));
    send_word(make_announce(32'd18200, 32'h0000_1234, $urandom, 16'($urandom), 1'b0, 1'b1,
                            '0));
    send_word(make_announce(32'd18300, 32'h0000_1234, $urandom, 16'($urandom), 1'b1, 1'b0,
                            '0));
    for (int i = 0; i < TABLE_DEPTH; i++)
      send_word(make_command(FUNC_READ, 32'd18400, 4'(i)));
    wait_results_drained();
  endtask

  // One register setting with its own time scale and key pool.
  task automatic run_random_phase(logic [31:0] lid, logic [31:0] age,
                                  int unsigned step, logic [31:0] base, int count);
    apply_settings(lid, age);
    tick_step = step;
    time_base = base;
    foreach (key_pool[k]) key_pool[k] = $urandom;
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) begin
        // One stretch in four, chosen at random, runs flat out on both sides.
        if ($urandom_range(0, 3) == 0) begin
          gap_pct   = 0;
          stall_pct = 0;
        end else begin
          gap_pct   = $urandom_range(5, 50);
          stall_pct = $urandom_range(5, 50);
        end
      end
      // Now and then hold the sender until the table has answered everything.
      if (n % 97 == 96) wait_results_drained();
      send_word(make_random_word());
    end
  endtask

  // Walk through register settings, the extremes among them, with time
  // wrapping past zero in some of the phases.
  task automatic test_random_traffic();
    run_random_phase(LOCAL_ID_RESET, AGE_LIMIT_RESET, 3000, 32'd0, 205);
    run_random_phase('0, '0, 3, $urandom, 205);
    run_random_phase('1, '1, 32'h7FFF_FFFF, $urandom, 205);
    run_random_phase($urandom, 32'd500, 120, 32'hFFFF_F000, 205);
    run_random_phase($urandom, 32'd5000, 900, $urandom, 205);
    run_random_phase($urandom, 32'd1, 2, $urandom, 205);
    run_random_phase($urandom, 32'h8000_0000, 32'h4000_0000, $urandom, 205);
    run_random_phase(LOCAL_ID_RESET, 32'd80000, 20000, 32'hFFFF_8000, 205);
    wait_results_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_directed_table();
    test_zero_local_id();
    test_random_traffic();
    wait_results_drained();
    // Give a stray word time to surface after the last expected one.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d announcements (%0d inserted, %0d refreshed, %0d dropped, %0d own),",
             n_by_func[FUNC_ANNOUNCE], n_by_status[STAT_INSERTED], n_by_status[STAT_UPDATED],
             n_by_status[STAT_FULL], n_by_status[STAT_OWN]);
    $display("%0d sweeps aging out %0d entries, %0d reads (%0d hits), %0d no-ops, %0d settings",
             n_by_func[FUNC_SWEEP], n_expired, n_by_func[FUNC_READ], n_read_valid,
             n_by_func[FUNC_UNUSED], settings_applied);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/plta_pkg.sv
rtl/core/plta_mem.sv
rtl/core/plta_seq.sv
rtl/core/peer_learning_table_aging_core.sv
rtl/core/plta_checker.sv
sim/tb_top.sv
